// ===== rtl/akf_pkg.sv =====
// Shared types, register-file map, fixed-point helpers and the microcode ROM for the altitude filter.
package akf_pkg;

	// Item op codes
	localparam logic [1:0] OP_UPDATE    = 2'd0;
	localparam logic [1:0] OP_SET_VEL   = 2'd1;
	localparam logic [1:0] OP_RESET_COV = 2'd2;
	localparam logic [1:0] OP_NONE      = 2'd3;

	// Configuration register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_BIAS_DECAY = 2'd0;
	localparam logic [1:0] REG_MEAS_NOISE = 2'd1;
	localparam logic [1:0] REG_PROC_ONE   = 2'd2;
	localparam logic [1:0] REG_PROC_TWO   = 2'd3;

	// Q16.16 constants
	localparam logic signed [31:0] FX_ONE     = 32'sd65536;
	localparam logic signed [31:0] FX_HUNDRED = 32'sd6553600;
	localparam logic signed [31:0] FX_MAX     = 32'sh7fffffff;
	localparam logic signed [31:0] FX_MIN     = 32'sh80000000;

	// Operand address map: bit 5 clear selects the register file,
	// bit 5 set selects configuration, item fields and constants.
	localparam logic [5:0] R_ALT  = 6'd0;
	localparam logic [5:0] R_VEL  = 6'd1;
	localparam logic [5:0] R_BIAS = 6'd2;
	localparam logic [5:0] R_C11  = 6'd3;
	localparam logic [5:0] R_C12  = 6'd4;
	localparam logic [5:0] R_C13  = 6'd5;
	localparam logic [5:0] R_C21  = 6'd6;
	localparam logic [5:0] R_C22  = 6'd7;
	localparam logic [5:0] R_C23  = 6'd8;
	localparam logic [5:0] R_C31  = 6'd9;
	localparam logic [5:0] R_C32  = 6'd10;
	localparam logic [5:0] R_C33  = 6'd11;
	localparam logic [5:0] R_T0   = 6'd12;
	localparam logic [5:0] R_T1   = 6'd13;
	localparam logic [5:0] R_F    = 6'd14;
	localparam logic [5:0] R_PV   = 6'd15;
	localparam logic [5:0] R_PA   = 6'd16;
	localparam logic [5:0] R_PB   = 6'd17;
	localparam logic [5:0] R_P11  = 6'd18;
	localparam logic [5:0] R_P12  = 6'd19;
	localparam logic [5:0] R_P13  = 6'd20;
	localparam logic [5:0] R_P21  = 6'd21;
	localparam logic [5:0] R_P22  = 6'd22;
	localparam logic [5:0] R_P23  = 6'd23;
	localparam logic [5:0] R_P31  = 6'd24;
	localparam logic [5:0] R_P32  = 6'd25;
	localparam logic [5:0] R_P33  = 6'd26;
	localparam logic [5:0] R_S    = 6'd27;
	localparam logic [5:0] R_OM   = 6'd27;  // shares S, which is dead once the gains exist
	localparam logic [5:0] R_K1   = 6'd28;
	localparam logic [5:0] R_K2   = 6'd29;
	localparam logic [5:0] R_K3   = 6'd30;
	localparam logic [5:0] R_E    = 6'd31;
	localparam logic [5:0] R_BETA    = 6'd32;
	localparam logic [5:0] R_RN      = 6'd33;
	localparam logic [5:0] R_Q1      = 6'd34;
	localparam logic [5:0] R_Q2      = 6'd35;
	localparam logic [5:0] R_Z       = 6'd36;
	localparam logic [5:0] R_ACC     = 6'd37;
	localparam logic [5:0] R_DT      = 6'd38;
	localparam logic [5:0] R_NEWV    = 6'd39;
	localparam logic [5:0] R_ONE     = 6'd40;
	localparam logic [5:0] R_HUNDRED = 6'd41;
	localparam logic [5:0] R_ZERO    = 6'd42;

	// Entries below this index hold filter state with a defined reset value
	localparam logic [4:0] RF_STATE = 5'd12;

	// Microcode entry points
	localparam logic [6:0] PC_UPDATE    = 7'd0;
	localparam logic [6:0] PC_SET_VEL   = 7'd74;
	localparam logic [6:0] PC_RESET_COV = 7'd75;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] altitude_sample;
		logic signed [31:0] accel_sample;
		logic [16:0]        time_step;
		logic signed [31:0] new_velocity;
	} akf_in_t;

	typedef struct packed {
		logic signed [31:0] altitude_estimate;
		logic signed [31:0] velocity_estimate;
		logic signed [31:0] bias_estimate;
	} akf_out_t;

	typedef struct packed {
		logic signed [31:0] bias_decay;
		logic [30:0]        measurement_noise;
		logic [30:0]        process_noise_one;
		logic [30:0]        process_noise_two;
	} akf_cfg_t;

	typedef enum logic [1:0] {U_ADD, U_SUB, U_MUL, U_DIV} uop_kind_t;

	typedef struct packed {
		uop_kind_t  kind;
		logic [5:0] dst;
		logic [5:0] a;
		logic [5:0] b;
		logic       last;
	} uop_t;

	typedef enum logic [1:0] {WR_ALU, WR_MUL, WR_DIV} wr_src_t;

	// Controller to datapath
	typedef struct packed {
		logic       capture;
		logic       rd_en;
		logic [5:0] rd_a;
		logic [5:0] rd_b;
		logic       alu_sub;
		logic       mul_en;
		logic       div_start;
		logic       wr_en;
		wr_src_t    wr_src;
		logic [4:0] dst;
		logic       load_out;
	} akf_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
	} akf_sts_t;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] != v[31]) return v[32] ? FX_MIN : FX_MAX;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
		if ((&v[47:31]) || !(|v[47:31])) return v[31:0];
		return v[47] ? FX_MIN : FX_MAX;
	endfunction

	// Reset value of a state entry: covariance diagonal is 100, all else zero
	function automatic logic signed [31:0] state_reset(input logic [3:0] idx);
		if (idx == R_C11[3:0] || idx == R_C22[3:0] || idx == R_C33[3:0]) return FX_HUNDRED;
		return '0;
	endfunction

	// Microcode: predict, gain, correct, covariance update; then the short programs
	function automatic uop_t uop_rom(input logic [6:0] pc);
		uop_t u;
		unique case (pc)
			// f = 1 + beta*dt
			7'd0:  u = '{U_MUL, R_T0, R_BETA, R_DT, 1'b0};
			7'd1:  u = '{U_ADD, R_F, R_ONE, R_T0, 1'b0};
			// predicted velocity, altitude, bias
			7'd2:  u = '{U_SUB, R_T0, R_ACC, R_BIAS, 1'b0};
			7'd3:  u = '{U_MUL, R_T0, R_T0, R_DT, 1'b0};
			7'd4:  u = '{U_ADD, R_PV, R_VEL, R_T0, 1'b0};
			7'd5:  u = '{U_MUL, R_T0, R_VEL, R_DT, 1'b0};
			7'd6:  u = '{U_ADD, R_PA, R_ALT, R_T0, 1'b0};
			7'd7:  u = '{U_MUL, R_PB, R_BIAS, R_F, 1'b0};
			// p11
			7'd8:  u = '{U_ADD, R_T0, R_C31, R_C13, 1'b0};
			7'd9:  u = '{U_MUL, R_T1, R_DT, R_C33, 1'b0};
			7'd10: u = '{U_ADD, R_T0, R_T0, R_T1, 1'b0};
			7'd11: u = '{U_MUL, R_T1, R_DT, R_Q1, 1'b0};
			7'd12: u = '{U_ADD, R_T0, R_T0, R_T1, 1'b0};
			7'd13: u = '{U_MUL, R_T0, R_DT, R_T0, 1'b0};
			7'd14: u = '{U_SUB, R_P11, R_C11, R_T0, 1'b0};
			// p12
			7'd15: u = '{U_SUB, R_T0, R_C11, R_C32, 1'b0};
			7'd16: u = '{U_MUL, R_T1, R_DT, R_C31, 1'b0};
			7'd17: u = '{U_SUB, R_T0, R_T0, R_T1, 1'b0};
			7'd18: u = '{U_MUL, R_T0, R_DT, R_T0, 1'b0};
			7'd19: u = '{U_ADD, R_P12, R_T0, R_C12, 1'b0};
			// p13
			7'd20: u = '{U_MUL, R_T0, R_DT, R_C33, 1'b0};
			7'd21: u = '{U_SUB, R_T0, R_C13, R_T0, 1'b0};
			7'd22: u = '{U_MUL, R_P13, R_F, R_T0, 1'b0};
			// p21
			7'd23: u = '{U_SUB, R_T0, R_C11, R_C23, 1'b0};
			7'd24: u = '{U_MUL, R_T1, R_DT, R_C13, 1'b0};
			7'd25: u = '{U_SUB, R_T0, R_T0, R_T1, 1'b0};
			7'd26: u = '{U_MUL, R_T0, R_DT, R_T0, 1'b0};
			7'd27: u = '{U_ADD, R_P21, R_T0, R_C21, 1'b0};
			// p22
			7'd28: u = '{U_MUL, R_T0, R_DT, R_C11, 1'b0};
			7'd29: u = '{U_ADD, R_T1, R_C21, R_C12, 1'b0};
			7'd30: u = '{U_ADD, R_T0, R_T0, R_T1, 1'b0};
			7'd31: u = '{U_MUL, R_T0, R_DT, R_T0, 1'b0};
			7'd32: u = '{U_ADD, R_P22, R_T0, R_C22, 1'b0};
			// p23
			7'd33: u = '{U_MUL, R_T0, R_DT, R_C13, 1'b0};
			7'd34: u = '{U_ADD, R_T0, R_C23, R_T0, 1'b0};
			7'd35: u = '{U_MUL, R_P23, R_F, R_T0, 1'b0};
			// p31
			7'd36: u = '{U_MUL, R_T0, R_DT, R_C33, 1'b0};
			7'd37: u = '{U_SUB, R_T0, R_C31, R_T0, 1'b0};
			7'd38: u = '{U_MUL, R_P31, R_F, R_T0, 1'b0};
			// p32
			7'd39: u = '{U_MUL, R_T0, R_DT, R_C31, 1'b0};
			7'd40: u = '{U_ADD, R_T0, R_C32, R_T0, 1'b0};
			7'd41: u = '{U_MUL, R_P32, R_F, R_T0, 1'b0};
			// p33
			7'd42: u = '{U_MUL, R_T0, R_F, R_F, 1'b0};
			7'd43: u = '{U_MUL, R_T0, R_T0, R_C33, 1'b0};
			7'd44: u = '{U_MUL, R_T1, R_DT, R_DT, 1'b0};
			7'd45: u = '{U_MUL, R_T1, R_T1, R_Q2, 1'b0};
			7'd46: u = '{U_ADD, R_P33, R_T0, R_T1, 1'b0};
			// innovation variance and gains
			7'd47: u = '{U_ADD, R_S, R_P22, R_RN, 1'b0};
			7'd48: u = '{U_DIV, R_K1, R_P12, R_S, 1'b0};
			7'd49: u = '{U_DIV, R_K2, R_P22, R_S, 1'b0};
			7'd50: u = '{U_DIV, R_K3, R_P32, R_S, 1'b0};
			// state correction
			7'd51: u = '{U_SUB, R_E, R_Z, R_PA, 1'b0};
			7'd52: u = '{U_MUL, R_T0, R_K1, R_E, 1'b0};
			7'd53: u = '{U_ADD, R_VEL, R_PV, R_T0, 1'b0};
			7'd54: u = '{U_MUL, R_T0, R_K2, R_E, 1'b0};
			7'd55: u = '{U_ADD, R_ALT, R_PA, R_T0, 1'b0};
			7'd56: u = '{U_MUL, R_T0, R_K3, R_E, 1'b0};
			7'd57: u = '{U_ADD, R_BIAS, R_PB, R_T0, 1'b0};
			// covariance update
			7'd58: u = '{U_SUB, R_OM, R_ONE, R_K2, 1'b0};
			7'd59: u = '{U_MUL, R_T0, R_K1, R_P21, 1'b0};
			7'd60: u = '{U_SUB, R_C11, R_P11, R_T0, 1'b0};
			7'd61: u = '{U_MUL, R_T0, R_K1, R_P22, 1'b0};
			7'd62: u = '{U_SUB, R_C12, R_P12, R_T0, 1'b0};
			7'd63: u = '{U_MUL, R_T0, R_K1, R_P23, 1'b0};
			7'd64: u = '{U_SUB, R_C13, R_P13, R_T0, 1'b0};
			7'd65: u = '{U_MUL, R_C21, R_P21, R_OM, 1'b0};
			7'd66: u = '{U_MUL, R_C22, R_P22, R_OM, 1'b0};
			7'd67: u = '{U_MUL, R_C23, R_P23, R_OM, 1'b0};
			7'd68: u = '{U_MUL, R_T0, R_K3, R_P21, 1'b0};
			7'd69: u = '{U_SUB, R_C31, R_P31, R_T0, 1'b0};
			7'd70: u = '{U_MUL, R_T0, R_K3, R_P22, 1'b0};
			7'd71: u = '{U_SUB, R_C32, R_P32, R_T0, 1'b0};
			7'd72: u = '{U_MUL, R_T0, R_K3, R_P23, 1'b0};
			7'd73: u = '{U_SUB, R_C33, R_P33, R_T0, 1'b1};
			// set velocity
			7'd74: u = '{U_ADD, R_VEL, R_NEWV, R_ZERO, 1'b1};
			// covariance reset
			7'd75: u = '{U_ADD, R_C11, R_HUNDRED, R_ZERO, 1'b0};
			7'd76: u = '{U_ADD, R_C12, R_ZERO, R_ZERO, 1'b0};
			7'd77: u = '{U_ADD, R_C13, R_ZERO, R_ZERO, 1'b0};
			7'd78: u = '{U_ADD, R_C21, R_ZERO, R_ZERO, 1'b0};
			7'd79: u = '{U_ADD, R_C22, R_HUNDRED, R_ZERO, 1'b0};
			7'd80: u = '{U_ADD, R_C23, R_ZERO, R_ZERO, 1'b0};
			7'd81: u = '{U_ADD, R_C31, R_ZERO, R_ZERO, 1'b0};
			7'd82: u = '{U_ADD, R_C32, R_ZERO, R_ZERO, 1'b0};
			7'd83: u = '{U_ADD, R_C33, R_HUNDRED, R_ZERO, 1'b1};
			default: u = '{U_ADD, R_T0, R_ZERO, R_ZERO, 1'b1};
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/akf_div.sv =====
// Gain divider: round-to-nearest (a * 2^16) / s, one quotient bit per cycle, saturated.
module akf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);

	localparam int MW = 51;  // dividend magnitude width
	localparam int DW = 33;  // divisor 2*s
	localparam int RW = 34;  // partial remainder

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic [MW-1:0] m_q;
	logic [RW-1:0] rem_q;
	logic [DW-1:0] d_q;
	logic          neg_q;
	logic          zero_q;

	logic signed [MW-1:0] n_full;
	logic [DW-1:0]        d_new;
	logic [MW-1:0]        m_new;
	logic [RW-1:0]        trial;
	logic                 fits;

	// Dividend 2*a*2^16 + s over divisor 2*s; floor on magnitudes
	always_comb begin
		n_full = $signed({{2{num[31]}}, num, 17'b0}) + MW'(den);
		d_new  = {den[31:0], 1'b0};
		if (n_full[MW-1]) m_new = (-n_full) + MW'(d_new) - MW'(1);
		else              m_new = n_full;
		trial = {rem_q[RW-2:0], m_q[MW-1]};
		fits  = (trial >= {1'b0, d_q});
	end

	// Restoring division sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			zero_q <= 1'b0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				zero_q <= (den <= 0);
				neg_q  <= n_full[MW-1];
				cnt_q  <= 6'(MW - 1);
				if (den <= 0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient shifts in where the dividend shifts out
	always_ff @(posedge clk) begin
		if (start) begin
			m_q   <= m_new;
			d_q   <= d_new;
			rem_q <= '0;
		end else if (busy_q) begin
			m_q   <= {m_q[MW-2:0], fits};
			rem_q <= fits ? (trial - {1'b0, d_q}) : trial;
		end
	end

	// Sign and saturation
	always_comb begin
		if (zero_q) begin
			quo = '0;
		end else if (!neg_q) begin
			quo = (|m_q[MW-1:31]) ? akf_pkg::FX_MAX : $signed(m_q[31:0]);
		end else begin
			if ((|m_q[MW-1:32]) || (m_q[31] && (|m_q[30:0]))) quo = akf_pkg::FX_MIN;
			else quo = $signed(-m_q[31:0]);
		end
	end

	assign done = done_q;

endmodule

// ===== rtl/akf_datapath.sv =====
// Datapath: register file, saturating adder, shared multiplier and gain divider.
module akf_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  akf_pkg::akf_cmd_t cmd,
	output akf_pkg::akf_sts_t sts,
	input  akf_pkg::akf_in_t  item,
	input  akf_pkg::akf_cfg_t cfg,
	output akf_pkg::akf_out_t result
);

	logic signed [31:0] mem [32];
	logic [11:0]        valid_q;

	logic signed [31:0] z_q;
	logic signed [31:0] acc_q;
	logic [16:0]        dt_q;
	logic signed [31:0] newv_q;

	logic signed [31:0] rd_a_q;
	logic signed [31:0] rd_b_q;
	logic signed [63:0] prod_s1;

	logic signed [31:0] alt_q;
	logic signed [31:0] vel_q;
	logic signed [31:0] bias_q;
	akf_pkg::akf_out_t  res_q;

	logic signed [32:0] alu_wide;
	logic signed [31:0] alu_res;
	logic signed [63:0] prod_rnd;
	logic signed [31:0] mul_res;
	logic signed [31:0] div_res;
	logic               div_done;
	logic signed [31:0] wr_data;

	// Operand source: state entries read as reset value until first written
	function automatic logic signed [31:0] operand(input logic [5:0] addr,
	                                               input logic signed [31:0] word);
		logic signed [31:0] v;
		v = '0;
		if (!addr[5]) begin
			if (addr[4:0] < akf_pkg::RF_STATE && !valid_q[addr[3:0]])
				v = akf_pkg::state_reset(addr[3:0]);
			else
				v = word;
		end else begin
			case (addr)
				akf_pkg::R_BETA:    v = cfg.bias_decay;
				akf_pkg::R_RN:      v = $signed({1'b0, cfg.measurement_noise});
				akf_pkg::R_Q1:      v = $signed({1'b0, cfg.process_noise_one});
				akf_pkg::R_Q2:      v = $signed({1'b0, cfg.process_noise_two});
				akf_pkg::R_Z:       v = z_q;
				akf_pkg::R_ACC:     v = acc_q;
				akf_pkg::R_DT:      v = $signed({15'b0, dt_q});
				akf_pkg::R_NEWV:    v = newv_q;
				akf_pkg::R_ONE:     v = akf_pkg::FX_ONE;
				akf_pkg::R_HUNDRED: v = akf_pkg::FX_HUNDRED;
				default:            v = '0;
			endcase
		end
		return v;
	endfunction

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			z_q    <= item.altitude_sample;
			acc_q  <= item.accel_sample;
			dt_q   <= item.time_step;
			newv_q <= item.new_velocity;
		end
	end

	// Register file: registered two-port read, single write
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_a_q <= operand(cmd.rd_a, mem[cmd.rd_a[4:0]]);
			rd_b_q <= operand(cmd.rd_b, mem[cmd.rd_b[4:0]]);
		end
		if (cmd.wr_en) mem[cmd.dst] <= wr_data;
	end

	// Multiplier stage
	always_ff @(posedge clk) begin
		if (cmd.mul_en) prod_s1 <= rd_a_q * rd_b_q;
	end

	// Add/sub, round of the product, write-back select
	always_comb begin
		if (cmd.alu_sub) alu_wide = {rd_a_q[31], rd_a_q} - {rd_b_q[31], rd_b_q};
		else             alu_wide = {rd_a_q[31], rd_a_q} + {rd_b_q[31], rd_b_q};
		alu_res  = akf_pkg::sat33(alu_wide);
		prod_rnd = prod_s1 + 64'sd32768;
		mul_res  = akf_pkg::sat48(prod_rnd[63:16]);
		case (cmd.wr_src)
			akf_pkg::WR_ALU: wr_data = alu_res;
			akf_pkg::WR_MUL: wr_data = mul_res;
			default:         wr_data = div_res;
		endcase
	end

	akf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (rd_a_q),
		.den    (rd_b_q),
		.done   (div_done),
		.quo    (div_res)
	);

	// Valid bits and estimate shadows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			alt_q   <= '0;
			vel_q   <= '0;
			bias_q  <= '0;
		end else if (cmd.wr_en) begin
			if (cmd.dst < akf_pkg::RF_STATE) valid_q[cmd.dst[3:0]] <= 1'b1;
			if (cmd.dst == akf_pkg::R_ALT[4:0])  alt_q  <= wr_data;
			if (cmd.dst == akf_pkg::R_VEL[4:0])  vel_q  <= wr_data;
			if (cmd.dst == akf_pkg::R_BIAS[4:0]) bias_q <= wr_data;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.altitude_estimate <= alt_q;
			res_q.velocity_estimate <= vel_q;
			res_q.bias_estimate     <= bias_q;
		end
	end

	assign sts.div_done = div_done;
	assign result       = res_q;

endmodule

// ===== rtl/akf_ctrl.sv =====
// Controller: microcode sequencer and input/output handshake.
module akf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        item_op,
	output logic              result_valid,
	input  logic              result_stall,
	output akf_pkg::akf_cmd_t cmd,
	input  akf_pkg::akf_sts_t sts
);

	typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_FIN} state_t;

	state_t        state_q;
	logic [6:0]    pc_q;
	logic          out_valid_q;
	akf_pkg::uop_t uop;
	logic          accept;
	logic          out_free;

	assign uop        = akf_pkg::uop_rom(pc_q);
	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !out_valid_q || !result_stall;

	// Commands to the datapath
	always_comb begin
		cmd           = '0;
		cmd.capture   = accept;
		cmd.rd_en     = (state_q == S_READ);
		cmd.rd_a      = uop.a;
		cmd.rd_b      = uop.b;
		cmd.alu_sub   = (uop.kind == akf_pkg::U_SUB);
		cmd.dst       = uop.dst[4:0];
		cmd.mul_en    = (state_q == S_EXEC) && (uop.kind == akf_pkg::U_MUL);
		cmd.div_start = (state_q == S_EXEC) && (uop.kind == akf_pkg::U_DIV);
		cmd.wr_src    = akf_pkg::WR_ALU;
		if (state_q == S_EXEC && (uop.kind == akf_pkg::U_ADD || uop.kind == akf_pkg::U_SUB))
			cmd.wr_en = 1'b1;
		if (state_q == S_MUL) begin
			cmd.wr_en  = 1'b1;
			cmd.wr_src = akf_pkg::WR_MUL;
		end
		if (state_q == S_DIV) begin
			cmd.wr_en  = sts.div_done;
			cmd.wr_src = akf_pkg::WR_DIV;
		end
		cmd.load_out  = (state_q == S_FIN) && out_free;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_valid_q && !result_stall) out_valid_q <= 1'b0;

			if (cmd.wr_en) begin
				if (uop.last) state_q <= S_FIN;
				else begin
					pc_q    <= pc_q + 7'd1;
					state_q <= S_READ;
				end
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept) begin
							unique case (item_op)
								akf_pkg::OP_UPDATE: begin
									pc_q    <= akf_pkg::PC_UPDATE;
									state_q <= S_READ;
								end
								akf_pkg::OP_SET_VEL: begin
									pc_q    <= akf_pkg::PC_SET_VEL;
									state_q <= S_READ;
								end
								akf_pkg::OP_RESET_COV: begin
									pc_q    <= akf_pkg::PC_RESET_COV;
									state_q <= S_READ;
								end
								default: state_q <= S_FIN;
							endcase
						end
					end
					S_READ: state_q <= S_EXEC;
					S_EXEC: begin
						if (uop.kind == akf_pkg::U_MUL) state_q <= S_MUL;
						else if (uop.kind == akf_pkg::U_DIV) state_q <= S_DIV;
					end
					S_MUL: state_q <= S_MUL;
					S_DIV: state_q <= S_DIV;
					S_FIN: if (out_free) state_q <= S_IDLE;
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign result_valid = out_valid_q;

endmodule

// ===== rtl/altitude_kalman_filter.sv =====
// Three-state altitude/velocity/bias Kalman filter, Q16.16, with APB configuration.
// Items are handled one at a time by a microcoded sequencer over a 32-entry register file
// with one saturating adder, one 32x32 multiplier and a bit-serial gain divider. An update
// item runs 74 micro-ops: 34 adds, 37 multiplies and three gain divisions of 51 quotient
// steps each, the three gain divisions dominating. Set-velocity and covariance-reset items
// run short programs and an unused op code runs none; then the result is loaded into the
// output register and the sequencer goes idle before the next item is taken.
// The result waits in an output register, so the next item is taken while a transaction is
// still stalled on the output side.
module altitude_kalman_filter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  akf_pkg::akf_in_t  item,
	output logic              result_valid,
	input  logic              result_stall,
	output akf_pkg::akf_out_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	akf_pkg::akf_cfg_t cfg_q;
	akf_pkg::akf_cmd_t cmd;
	akf_pkg::akf_sts_t sts;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bias_decay        <= '0;
			cfg_q.measurement_noise <= 31'(akf_pkg::FX_ONE);
			cfg_q.process_noise_one <= 31'(akf_pkg::FX_ONE);
			cfg_q.process_noise_two <= 31'(akf_pkg::FX_ONE);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				akf_pkg::REG_BIAS_DECAY: cfg_q.bias_decay        <= $signed(pwdata);
				akf_pkg::REG_MEAS_NOISE: cfg_q.measurement_noise <= pwdata[30:0];
				akf_pkg::REG_PROC_ONE:   cfg_q.process_noise_one <= pwdata[30:0];
				akf_pkg::REG_PROC_TWO:   cfg_q.process_noise_two <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (paddr[3:2])
			akf_pkg::REG_BIAS_DECAY: prdata = cfg_q.bias_decay;
			akf_pkg::REG_MEAS_NOISE: prdata = {1'b0, cfg_q.measurement_noise};
			akf_pkg::REG_PROC_ONE:   prdata = {1'b0, cfg_q.process_noise_one};
			akf_pkg::REG_PROC_TWO:   prdata = {1'b0, cfg_q.process_noise_two};
			default:                 prdata = '0;
		endcase
	end

	akf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item_op      (item.op),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.sts          (sts)
	);

	akf_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.item   (item),
		.cfg    (cfg_q),
		.result (result)
	);

endmodule

// ===== rtl/akf_checker.sv =====
// Port-level checker for the altitude filter, bound to the top level.
module akf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input akf_pkg::akf_out_t result,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [3:0]        paddr,
	input logic [31:0]       pwdata,
	input logic [31:0]       prdata,
	input logic              pready
);

	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = item_valid && !item_stall;
	assign out_acc = result_valid && !result_stall;

	// Items taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pending_q <= '0;
		else pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
	end

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Every transaction out answers an item taken earlier
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pending_q != 2'd0)
		else $error("result without an item");

	// At most one item in work plus one result waiting
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("too many items outstanding");

	// Written bias decay reads back
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[3:2] == akf_pkg::REG_BIAS_DECAY
		|=> !(psel && !pwrite && paddr[3:2] == akf_pkg::REG_BIAS_DECAY)
		    || prdata == $past(pwdata))
		else $error("bias decay readback mismatch");

endmodule

bind altitude_kalman_filter akf_checker u_akf_checker (.*);

// ===== verif/altitude_kalman_filter_tb.sv =====
// Self-checking testbench for the altitude Kalman filter: random items, APB setup, stalls.
`timescale 1ns / 1ps
module altitude_kalman_filter_tb;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	akf_pkg::akf_in_t  item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	akf_pkg::akf_out_t result;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [3:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	altitude_kalman_filter dut (.*);

	always #10 clk = ~clk;

	// Predictor state and configuration
	logic signed [31:0] m_alt, m_vel, m_bias;
	logic signed [31:0] m_cov [9];
	logic signed [31:0] m_beta, m_rn, m_q1, m_q2;

	akf_pkg::akf_in_t  pending_items [$];
	akf_pkg::akf_out_t expected_estimates [$];
	int  error_count = 0;
	int  result_count = 0;
	int  update_count = 0;
	longint cycle_count = 0;
	bit  hold_off = 1'b0;

	function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] qadd(input logic signed [31:0] a, b);
		return clamp(64'(a) + 64'(b));
	endfunction

	function automatic logic signed [31:0] qsub(input logic signed [31:0] a, b);
		return clamp(64'(a) - 64'(b));
	endfunction

	// Round to nearest, ties up: arithmetic shift floors
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a, b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + 64'sd32768;
		return clamp(p >>> 16);
	endfunction

	function automatic logic signed [31:0] qgain(input logic signed [31:0] a, s);
		logic signed [63:0] num, den, q;
		if (s <= 0) return '0;
		num = 64'(a) * 64'sd131072 + 64'(s);
		den = 64'(s) * 2;
		q = num / den;
		if (num < 0 && q * den != num) q = q - 1;
		return clamp(q);
	endfunction

	function automatic void reset_covariance();
		foreach (m_cov[i]) m_cov[i] = '0;
		m_cov[0] = akf_pkg::FX_HUNDRED;
		m_cov[4] = akf_pkg::FX_HUNDRED;
		m_cov[8] = akf_pkg::FX_HUNDRED;
	endfunction

	function automatic void filter_update(input logic signed [31:0] z, acc,
			input logic [16:0] dt_in);
		logic signed [31:0] dt, f, pv, pa, pb, s, k1, k2, k3, e, om;
		logic signed [31:0] p11, p12, p13, p21, p22, p23, p31, p32, p33;
		logic signed [31:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
		dt = {15'd0, dt_in};
		{e11, e12, e13, e21, e22, e23, e31, e32, e33} = {m_cov[0], m_cov[1], m_cov[2],
			m_cov[3], m_cov[4], m_cov[5], m_cov[6], m_cov[7], m_cov[8]};
		f = qadd(akf_pkg::FX_ONE, qmul(m_beta, dt));
		pv = qadd(m_vel, qmul(qsub(acc, m_bias), dt));
		pa = qadd(m_alt, qmul(m_vel, dt));
		pb = qmul(m_bias, f);
		p11 = qsub(e11, qmul(dt, qadd(qadd(qadd(e31, e13), qmul(dt, e33)), qmul(dt, m_q1))));
		p12 = qadd(qmul(dt, qsub(qsub(e11, e32), qmul(dt, e31))), e12);
		p13 = qmul(f, qsub(e13, qmul(dt, e33)));
		p21 = qadd(qmul(dt, qsub(qsub(e11, e23), qmul(dt, e13))), e21);
		p22 = qadd(qmul(dt, qadd(qmul(dt, e11), qadd(e21, e12))), e22);
		p23 = qmul(f, qadd(e23, qmul(dt, e13)));
		p31 = qmul(f, qsub(e31, qmul(dt, e33)));
		p32 = qmul(f, qadd(e32, qmul(dt, e31)));
		p33 = qadd(qmul(qmul(f, f), e33), qmul(qmul(dt, dt), m_q2));
		s = qadd(p22, m_rn);
		k1 = qgain(p12, s);
		k2 = qgain(p22, s);
		k3 = qgain(p32, s);
		e = qsub(z, pa);
		m_vel = qadd(pv, qmul(k1, e));
		m_alt = qadd(pa, qmul(k2, e));
		m_bias = qadd(pb, qmul(k3, e));
		om = qsub(akf_pkg::FX_ONE, k2);
		m_cov[0] = qsub(p11, qmul(k1, p21));
		m_cov[1] = qsub(p12, qmul(k1, p22));
		m_cov[2] = qsub(p13, qmul(k1, p23));
		m_cov[3] = qmul(p21, om);
		m_cov[4] = qmul(p22, om);
		m_cov[5] = qmul(p23, om);
		m_cov[6] = qsub(p31, qmul(k3, p21));
		m_cov[7] = qsub(p32, qmul(k3, p22));
		m_cov[8] = qsub(p33, qmul(k3, p23));
	endfunction

	function automatic akf_pkg::akf_out_t predict_estimates(input akf_pkg::akf_in_t it);
		case (it.op)
			akf_pkg::OP_UPDATE:
				filter_update(it.altitude_sample, it.accel_sample, it.time_step);
			akf_pkg::OP_SET_VEL: m_vel = it.new_velocity;
			akf_pkg::OP_RESET_COV: reset_covariance();
			default: ;
		endcase
		return '{m_alt, m_vel, m_bias};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, exp);
		$display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, exp, cycle_count);
		error_count++;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Driver: offers queued items, with random gaps
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				void'(pending_items.pop_front());
				expected_estimates.push_back(predict_estimates(item));
			end
			if (item_valid && item_stall) begin
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				item_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				item <= pending_items[0];
				item_valid <= 1'b1;
				send_gap <= gap_len();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks results and drives random output stalls
	int stall_gap = 0;
	always @(posedge clk) begin
		akf_pkg::akf_out_t exp_r;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				result_count++;
				if (expected_estimates.size() == 0) begin
					report_mismatch("unexpected result", result.altitude_estimate, '0);
				end else begin
					exp_r = expected_estimates.pop_front();
					if (result.altitude_estimate !== exp_r.altitude_estimate)
						report_mismatch("altitude", result.altitude_estimate, exp_r.altitude_estimate);
					if (result.velocity_estimate !== exp_r.velocity_estimate)
						report_mismatch("velocity", result.velocity_estimate, exp_r.velocity_estimate);
					if (result.bias_estimate !== exp_r.bias_estimate)
						report_mismatch("bias", result.bias_estimate, exp_r.bias_estimate);
				end
			end
			if (hold_off) begin
				result_stall <= 1'b1;
			end else if (stall_gap > 0) begin
				stall_gap <= stall_gap - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				stall_gap <= gap_len();
			end
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		if (cycle_count > 2000000) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("altitude_kalman_filter_tb: errors");
			$finish;
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			akf_pkg::REG_BIAS_DECAY: m_beta = val;
			akf_pkg::REG_MEAS_NOISE: m_rn = {1'b0, val[30:0]};
			akf_pkg::REG_PROC_ONE:   m_q1 = {1'b0, val[30:0]};
			default:                 m_q2 = {1'b0, val[30:0]};
		endcase
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || item_valid || expected_estimates.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] edge_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return 32'hffffffff;
			4: return $urandom_range(0, 32'h00ffffff);
			default: return $urandom;
		endcase
	endfunction

	// Mostly realistic samples; some full-range noise
	function automatic akf_pkg::akf_in_t random_item();
		akf_pkg::akf_in_t it;
		int r;
		r = $urandom_range(0, 99);
		it.op = r < 75 ? akf_pkg::OP_UPDATE : r < 85 ? akf_pkg::OP_SET_VEL
			: r < 93 ? akf_pkg::OP_RESET_COV : akf_pkg::OP_NONE;
		it.altitude_sample = $urandom_range(0, 9) == 0 ? edge_word()
			: 32'(int'($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
		it.accel_sample = $urandom_range(0, 9) == 0 ? edge_word()
			: 32'(int'($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
		it.time_step = $urandom_range(0, 9) == 0 ? 17'($urandom)
			: 17'($urandom_range(0, 2000));
		it.new_velocity = $urandom_range(0, 3) == 0 ? edge_word()
			: 32'(int'($urandom_range(0, 32'h003fffff)) - 32'sh00200000);
		return it;
	endfunction

	task automatic push(input logic [1:0] op, input logic [31:0] z, acc,
			input logic [16:0] dt, input logic [31:0] v);
		pending_items.push_back('{op, z, acc, dt, v});
	endtask

	initial begin
		akf_pkg::akf_in_t it;
		m_alt = '0; m_vel = '0; m_bias = '0;
		reset_covariance();
		m_beta = '0; m_rn = akf_pkg::FX_ONE; m_q1 = akf_pkg::FX_ONE; m_q2 = akf_pkg::FX_ONE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: every op, field extremes, large time step, non-positive variance
		push(akf_pkg::OP_UPDATE, 32'h00010000, 32'h0, 17'd655, '0);
		push(akf_pkg::OP_UPDATE, 32'h7fffffff, 32'h7fffffff, 17'h1ffff, '0);
		push(akf_pkg::OP_UPDATE, 32'h80000000, 32'h80000000, 17'd65536, '0);
		push(akf_pkg::OP_SET_VEL, '0, '0, '0, 32'h7fffffff);
		push(akf_pkg::OP_UPDATE, '0, '0, 17'd0, 32'h80000000);
		push(akf_pkg::OP_SET_VEL, 32'hffffffff, 32'hffffffff, 17'h1ffff, 32'h80000000);
		push(akf_pkg::OP_NONE, 32'h12345678, 32'h9abcdef0, 17'h15555, 32'h55555555);
		push(akf_pkg::OP_RESET_COV, '0, '0, '0, '0);
		push(akf_pkg::OP_UPDATE, 32'h00020000, 32'hfff00000, 17'd1000, '0);
		push(akf_pkg::OP_NONE, 32'hffffffff, '0, 17'h0aaaa, 32'haaaaaaaa);
		drain();
		// Register extremes: largest R, most negative beta, no q1, largest q2
		apb_write(akf_pkg::REG_MEAS_NOISE, 32'h7fffffff);
		apb_write(akf_pkg::REG_BIAS_DECAY, 32'h80000000);
		apb_write(akf_pkg::REG_PROC_ONE, 32'h0);
		apb_write(akf_pkg::REG_PROC_TWO, 32'h7fffffff);
		push(akf_pkg::OP_UPDATE, 32'h00050000, 32'h00010000, 17'd65536, '0);
		push(akf_pkg::OP_UPDATE, 32'h7fffffff, '0, 17'h1ffff, '0);
		push(akf_pkg::OP_RESET_COV, '0, '0, '0, '0);
		push(akf_pkg::OP_UPDATE, 32'h80000000, 32'h7fffffff, 17'd300, '0);
		drain();

		// Random phases, each with new register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin apb_write(akf_pkg::REG_BIAS_DECAY, 32'h0);
					apb_write(akf_pkg::REG_MEAS_NOISE, 32'h10000);
					apb_write(akf_pkg::REG_PROC_ONE, 32'h10000);
					apb_write(akf_pkg::REG_PROC_TWO, 32'h10000); end
				1: begin apb_write(akf_pkg::REG_BIAS_DECAY, 32'h7fffffff);
					apb_write(akf_pkg::REG_MEAS_NOISE, 32'h0);
					apb_write(akf_pkg::REG_PROC_ONE, 32'h7fffffff);
					apb_write(akf_pkg::REG_PROC_TWO, 32'h0); end
				default: begin apb_write(akf_pkg::REG_BIAS_DECAY, $urandom);
					apb_write(akf_pkg::REG_MEAS_NOISE, $urandom_range(0, 32'h000fffff));
					apb_write(akf_pkg::REG_PROC_ONE, $urandom);
					apb_write(akf_pkg::REG_PROC_TWO, $urandom); end
			endcase
			if (ph == 2) hold_off = 1'b1;
			for (int n = 0; n < 100; n++) pending_items.push_back(random_item());
			if (ph == 2) begin
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			drain();
		end

		$display("covered %0d results over directed items and six register settings", result_count);
		$display("including a long output hold-off; %0d mismatches", error_count);
		if (error_count == 0)
			$display("altitude_kalman_filter_tb: clean");
		else
			$display("altitude_kalman_filter_tb: errors");
		$finish;
	end

endmodule
